FILE: rtl/core/debounced_rotary_encoder_counter_unit_assert.svh
// Assertion macros for the rotary encoder counter and its checker
`ifndef DEBOUNCED_ROTARY_ENCODER_COUNTER_UNIT_ASSERT_SVH
`define DEBOUNCED_ROTARY_ENCODER_COUNTER_UNIT_ASSERT_SVH

// check a consequent in the same cycle as its antecedent
`define DREC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("drec assertion failed");

// check a consequent in the cycle after its antecedent
`define DREC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("drec assertion failed");

`endif

FILE: rtl/core/drec_pkg.sv
// Package with transfer types and constants of the rotary encoder counter
`default_nettype none

package drec_pkg;

  localparam int unsigned TicksBits = 16;
  localparam int unsigned PendingBits = 16;
  localparam logic [TicksBits-1:0] TicksReset = 16'd10;
  localparam logic [TicksBits-1:0] SettleMax = 16'hFFFF;

  typedef struct packed {
    logic clk_level;
    logic dt_level;
    logic take_left;
    logic take_right;
  } drec_in_t;

  typedef struct packed {
    logic                          left_taken;
    logic                          right_taken;
    logic signed [PendingBits-1:0] pending_count;
    logic                          settling;
  } drec_out_t;

endpackage

`default_nettype wire

FILE: rtl/core/debounced_rotary_encoder_counter_unit.sv
// Debounced rotary encoder decoder with a saturating pending pulse counter
//
// Input channel (in_valid_i / in_ready_o / in_data_i): one transfer per sample
// period, carrying the encoder clock and data pin levels and two requests to
// take one pending left or right pulse.
// Output channel (out_valid_o / out_ready_i / out_data_o): exactly one
// transfer per input transfer, in order, with the taken flags, the pending
// count after the sample and the settling flag.
// Configuration: cfg_we_i writes cfg_wdata_i into the stability tick count;
// write it only while no transfer is in flight.
// An input transfer passes through one input register, then the decode and
// count update into the output register, before its output transfer.
// Throughput is one transfer per cycle while the receiver takes outputs, as
// the debounce state and pulse counter update with each move to the output.
// Reset clears the debounce state, the counter and both pipeline stages and
// loads the stability tick count with 10.
// A stalled receiver holds the output register; the input register still
// takes one more transfer, after which in_ready_o drops until the output moves.
`default_nettype none

module debounced_rotary_encoder_counter_unit #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output      logic                                 in_ready_o,
  input  wire drec_pkg::drec_in_t                   in_data_i,
  output      logic                                 out_valid_o,
  input  wire logic                                 out_ready_i,
  output      drec_pkg::drec_out_t                  out_data_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic [drec_pkg::TicksBits-1:0]       cfg_wdata_i
);

  localparam logic signed [COUNT_BITS-1:0] BalMax = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam logic signed [COUNT_BITS-1:0] BalMin = {1'b1, {(COUNT_BITS-1){1'b0}}};
  localparam logic signed [COUNT_BITS-1:0] BalOne = COUNT_BITS'(1);

  logic [drec_pkg::TicksBits-1:0] ticks_q;

  logic               s1_valid_q;
  drec_pkg::drec_in_t s1_data_q;
  logic               out_valid_q;
  drec_pkg::drec_out_t out_data_q, out_data_d;

  logic                           changed_q, changed_d;
  logic                           prev_clk_q;
  logic                           cap_clk_q, cap_clk_d;
  logic                           cap_dt_q, cap_dt_d;
  logic [drec_pkg::TicksBits-1:0] settle_q, settle_d;
  logic signed [COUNT_BITS-1:0]   bal_q, bal_d;

  logic s2_free, s1_go, in_fire;
  logic clk_chg, cleared;
  logic signed [COUNT_BITS-1:0] bal_s, bal_l;
  logic left_ok, right_ok;
  logic signed [31:0] bal_wide;

  assign s2_free    = !out_valid_q || out_ready_i;
  assign s1_go      = s1_valid_q && s2_free;
  assign in_ready_o = !s1_valid_q || s1_go;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    clk_chg   = s1_data_q.clk_level != prev_clk_q;
    cleared   = 1'b0;
    changed_d = changed_q;
    cap_clk_d = cap_clk_q;
    cap_dt_d  = cap_dt_q;
    bal_s     = bal_q;
    if (!changed_q) begin
      if (clk_chg) begin
        cap_clk_d = s1_data_q.clk_level;
        cap_dt_d  = s1_data_q.dt_level;
        cleared   = 1'b1;
        changed_d = 1'b1;
      end
    end else if (clk_chg) begin
      cleared = 1'b1;
    end else if (settle_q >= ticks_q) begin
      if (!s1_data_q.clk_level && !cap_clk_q) begin
        if (cap_dt_q) begin
          if (bal_q != BalMax) begin
            bal_s = bal_q + BalOne;
          end
        end else if (bal_q != BalMin) begin
          bal_s = bal_q - BalOne;
        end
      end
      changed_d = 1'b0;
    end

    if (cleared) begin
      settle_d = '0;
    end else if (settle_q != drec_pkg::SettleMax) begin
      settle_d = settle_q + 16'd1;
    end else begin
      settle_d = settle_q;
    end

    left_ok  = s1_data_q.take_left && bal_s[COUNT_BITS-1];
    bal_l    = left_ok ? bal_s + BalOne : bal_s;
    right_ok = s1_data_q.take_right && !bal_l[COUNT_BITS-1] && (bal_l != '0);
    bal_d    = right_ok ? bal_l - BalOne : bal_l;

    bal_wide = 32'(bal_d);
    out_data_d.left_taken    = left_ok;
    out_data_d.right_taken   = right_ok;
    out_data_d.pending_count = bal_wide[drec_pkg::PendingBits-1:0];
    out_data_d.settling      = changed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= drec_pkg::TicksReset;
    end else if (cfg_we_i) begin
      ticks_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_data_q <= in_data_i;
    end
    if (s1_go) begin
      out_data_q <= out_data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      changed_q  <= 1'b0;
      prev_clk_q <= 1'b0;
      cap_clk_q  <= 1'b0;
      cap_dt_q   <= 1'b0;
      settle_q   <= '0;
      bal_q      <= '0;
    end else if (s1_go) begin
      changed_q  <= changed_d;
      prev_clk_q <= s1_data_q.clk_level;
      cap_clk_q  <= cap_clk_d;
      cap_dt_q   <= cap_dt_d;
      settle_q   <= settle_d;
      bal_q      <= bal_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

FILE: rtl/core/drec_checker.sv
// Port checker for the rotary encoder counter and its bind to the top level
`default_nettype none
`include "debounced_rotary_encoder_counter_unit_assert.svh"

module drec_checker #(
  parameter int unsigned COUNT_BITS = 16
) (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           out_valid_o,
  input wire logic                           out_ready_i,
  input wire drec_pkg::drec_out_t            out_data_o
);

  `DREC_ASSERT_NEXT(a_out_valid_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `DREC_ASSERT_NEXT(a_out_data_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(out_data_o))
  `DREC_ASSERT_NOW(a_one_take, clk_i, rst_ni, out_valid_o, !(out_data_o.left_taken && out_data_o.right_taken))
  `DREC_ASSERT_NOW(a_left_sign, clk_i, rst_ni, out_valid_o && out_data_o.left_taken, (COUNT_BITS > 16) || (out_data_o.pending_count <= 0))
  `DREC_ASSERT_NOW(a_right_sign, clk_i, rst_ni, out_valid_o && out_data_o.right_taken, (COUNT_BITS > 16) || (out_data_o.pending_count >= 0))

endmodule

bind debounced_rotary_encoder_counter_unit drec_checker #(
  .COUNT_BITS (COUNT_BITS)
) u_drec_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

FILE: sim/debounced_rotary_encoder_counter_checker.sv
`timescale 1ns / 1ps
// Checker that predicts the decoder output of every input transfer and compares it
module debounced_rotary_encoder_counter_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  drec_pkg::drec_in_t        in_data_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  drec_pkg::drec_out_t       out_data_i,
  input  logic                      cfg_we_i,
  input  logic [drec_pkg::TicksBits-1:0] cfg_wdata_i,
  output int                        fail_cnt_o,
  output int                        due_cnt_o
);
  import drec_pkg::*;

  localparam logic signed [PendingBits-1:0] CountMax = {1'b0, {(PendingBits-1){1'b1}}};
  localparam logic signed [PendingBits-1:0] CountMin = {1'b1, {(PendingBits-1){1'b0}}};

  logic [TicksBits-1:0]          ticks_q;
  logic                          changed_q;
  logic                          prev_clk_q;
  logic                          cap_clk_q;
  logic                          cap_dt_q;
  logic [TicksBits-1:0]          settle_q;
  logic signed [PendingBits-1:0] balance_q;
  drec_out_t                     want_r;
  drec_out_t                     predicted_out_q[$];

  task automatic decode_sample(input drec_in_t s, output drec_out_t r);
    logic cleared;
    cleared = 1'b0;
    r = '0;
    if (!changed_q) begin
      if (s.clk_level != prev_clk_q) begin
        cap_clk_q = s.clk_level;
        cap_dt_q  = s.dt_level;
        settle_q  = '0;
        cleared   = 1'b1;
        changed_q = 1'b1;
      end
    end else if (s.clk_level != prev_clk_q) begin
      settle_q = '0;
      cleared  = 1'b1;
    end else if (settle_q >= ticks_q) begin
      if (!s.clk_level && !cap_clk_q) begin
        if (cap_dt_q) begin
          if (balance_q != CountMax) balance_q = balance_q + 16'sd1;
        end else begin
          if (balance_q != CountMin) balance_q = balance_q - 16'sd1;
        end
      end
      changed_q = 1'b0;
    end
    prev_clk_q = s.clk_level;
    if (!cleared && settle_q != SettleMax) settle_q = settle_q + 1'b1;
    if (s.take_left && balance_q < 0) begin
      balance_q    = balance_q + 16'sd1;
      r.left_taken = 1'b1;
    end
    if (s.take_right && balance_q > 0) begin
      balance_q     = balance_q - 16'sd1;
      r.right_taken = 1'b1;
    end
    r.pending_count = balance_q;
    r.settling      = changed_q;
  endtask

  task automatic check_field(input string field, input logic signed [31:0] want_v,
                             input logic signed [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, got %0d", field, want_v, got_v);
      fail_cnt_o++;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      ticks_q    = TicksReset;
      changed_q  = 1'b0;
      prev_clk_q = 1'b0;
      cap_clk_q  = 1'b0;
      cap_dt_q   = 1'b0;
      settle_q   = '0;
      balance_q  = '0;
      predicted_out_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (predicted_out_q.size() == 0) begin
          $error("output transfer with nothing due: %p", out_data_i);
          fail_cnt_o++;
        end else begin
          want_r = predicted_out_q.pop_front();
          check_field("left_taken", want_r.left_taken, out_data_i.left_taken);
          check_field("right_taken", want_r.right_taken, out_data_i.right_taken);
          check_field("pending_count", $signed(want_r.pending_count),
                      $signed(out_data_i.pending_count));
          check_field("settling", want_r.settling, out_data_i.settling);
        end
      end
      if (cfg_we_i) ticks_q = cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        decode_sample(in_data_i, want_r);
        predicted_out_q.push_back(want_r);
      end
    end
    due_cnt_o = predicted_out_q.size();
  end

endmodule

FILE: sim/debounced_rotary_encoder_counter_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top: drives samples and register writes into the encoder counter and reports
module debounced_rotary_encoder_counter_unit_tb;
  import drec_pkg::*;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned RandItems  = 520;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  drec_in_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  drec_out_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [TicksBits-1:0] cfg_wdata = '0;
  int                   fail_cnt;
  int                   due_cnt;
  bit                   idle_on   = 1'b1;
  int unsigned          hold_len  = 0;
  int unsigned          sent_cnt  = 0;
  int unsigned          cycle_cnt = 0;
  logic [TicksBits-1:0] cur_ticks = TicksReset;

  debounced_rotary_encoder_counter_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  debounced_rotary_encoder_counter_checker checker_i (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .out_data_i (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .fail_cnt_o (fail_cnt),
    .due_cnt_o  (due_cnt)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_sample(input logic clk_lvl, input logic dt_lvl,
                             input logic tk_left, input logic tk_right);
    int unsigned gap;
    gap = idle_on ? $urandom_range(11, 0) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{clk_level: clk_lvl, dt_level: dt_lvl,
                  take_left: tk_left, take_right: tk_right};
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
    sent_cnt++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (due_cnt != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_ticks(input logic [TicksBits-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_ticks  = value;
    @(negedge clk);
  endtask

  task automatic turn_detent(input logic dt_lvl);
    int unsigned bounces;
    int unsigned hold;
    bounces = $urandom_range(3, 0);
    for (int i = 0; i < bounces; i++)
      send_sample(i[0], 1'($urandom_range(1, 0)), $urandom_range(3, 0) == 0,
                  $urandom_range(3, 0) == 0);
    hold = cur_ticks + 1 + $urandom_range(2, 0);
    repeat (hold)
      send_sample(1'b0, dt_lvl, $urandom_range(3, 0) == 0, $urandom_range(3, 0) == 0);
    bounces = $urandom_range(3, 0);
    for (int i = 0; i < bounces; i++)
      send_sample(~i[0], 1'($urandom_range(1, 0)), $urandom_range(3, 0) == 0,
                  $urandom_range(3, 0) == 0);
    hold = cur_ticks + 1 + $urandom_range(2, 0);
    repeat (hold)
      send_sample(1'b1, 1'($urandom_range(1, 0)), $urandom_range(3, 0) == 0,
                  $urandom_range(3, 0) == 0);
  endtask

  task automatic noise_run();
    repeat ($urandom_range(8, 1))
      send_sample(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
                  1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
  endtask

  initial begin
    @(posedge rst_n);
    forever begin
      int unsigned gap;
      if (hold_len != 0) begin
        gap      = hold_len;
        hold_len = 0;
      end else begin
        gap = idle_on ? $urandom_range(11, 0) : 0;
      end
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  initial begin
    int unsigned phase;
    int unsigned rand_stop;
    int unsigned phase_stop;
    logic [TicksBits-1:0] ticks;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_sample(1'b0, 1'b0, 1'b1, 1'b1);
    send_sample(1'b0, 1'b1, 1'b0, 1'b0);
    send_sample(1'b1, 1'b1, 1'b0, 1'b0);
    send_sample(1'b0, 1'b0, 1'b0, 1'b0);
    send_sample(1'b1, 1'b0, 1'b0, 1'b0);

    write_ticks('0);
    send_sample(1'b1, 1'b0, 1'b0, 1'b0);
    send_sample(1'b1, 1'b0, 1'b0, 1'b0);
    send_sample(1'b0, 1'b1, 1'b0, 1'b0);
    send_sample(1'b0, 1'b0, 1'b1, 1'b0);
    send_sample(1'b1, 1'b0, 1'b0, 1'b0);
    send_sample(1'b1, 1'b1, 1'b1, 1'b1);
    send_sample(1'b0, 1'b0, 1'b0, 1'b0);
    send_sample(1'b0, 1'b1, 1'b1, 1'b1);
    send_sample(1'b1, 1'b1, 1'b0, 1'b0);
    send_sample(1'b0, 1'b1, 1'b0, 1'b0);
    send_sample(1'b0, 1'b1, 1'b0, 1'b1);
    send_sample(1'b1, 1'b0, 1'b0, 1'b0);
    send_sample(1'b1, 1'b0, 1'b0, 1'b0);

    phase     = 0;
    rand_stop = sent_cnt + RandItems;
    while (sent_cnt < rand_stop) begin
      case (phase % 6)
        0: ticks = 16'd2;
        1: ticks = 16'd0;
        2: ticks = 16'd1;
        3: ticks = 16'd4;
        4: ticks = TicksReset;
        default: ticks = 16'd3;
      endcase
      write_ticks(ticks);
      idle_on = (phase % 3) != 2;
      if (phase == 1) begin
        idle_on  = 1'b0;
        hold_len = 150;
      end
      phase_stop = sent_cnt + 90;
      while (sent_cnt < phase_stop && sent_cnt < rand_stop) begin
        if ($urandom_range(9, 0) < 7) turn_detent(1'($urandom_range(1, 0)));
        else noise_run();
      end
      phase++;
    end

    drain_results();
    repeat (8) @(negedge clk);
    if (fail_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
